// ----- hw/rtl/efdc_pkg.sv -----
// ----------------------------------------------------------------------------
// efdc_pkg: shared types, constants and calendar functions
// Holds the field widths, the reciprocal multipliers used for the
// constant divisions, the feast offsets and the month tables.
// ----------------------------------------------------------------------------
package efdc_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DOY_W   = 9;
	localparam int DOM_W   = 5;

	typedef logic [YEAR_W-1:0]  year_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [DOY_W-1:0]   doy_t;
	typedef logic [DOM_W-1:0]   dom_t;

	// Reciprocal multipliers: q = (x * MUL) >> SHIFT, exact over the value ranges in use.
	localparam logic [12:0] DIV100_MUL = 13'd5243;   // shift 19, x < 16384
	localparam logic [15:0] DIV19_MUL  = 16'd55189;  // shift 20, x < 16384
	localparam logic [5:0]  DIV25_MUL  = 6'd41;      // shift 10, x < 172
	localparam logic [9:0]  DIV3_MUL   = 10'd683;    // shift 11, x < 165
	localparam logic [10:0] DIV30_MUL  = 11'd1093;   // shift 15, x < 521
	localparam logic [8:0]  DIV7_MUL   = 9'd293;     // shift 11, x < 87

	// Feast offsets from Easter Sunday, in days.
	localparam doy_t FRIDAY_OFS    = 9'd2;
	localparam doy_t ASCENSION_OFS = 9'd39;
	localparam doy_t WHITSUN_OFS   = 9'd49;
	localparam doy_t CARNIVAL_OFS  = 9'd47;

	localparam month_t MON_FEB = 4'd2;
	localparam month_t MON_MAR = 4'd3;
	localparam month_t MON_APR = 4'd4;

	// Offset of the first day of month index mi (0 = January), leap day included.
	function automatic doy_t efdc_month_start(input logic [3:0] mi, input logic leap);
		doy_t base;
		begin
			case (mi)
				4'd0:    base = 9'd0;
				4'd1:    base = 9'd31;
				4'd2:    base = 9'd59;
				4'd3:    base = 9'd90;
				4'd4:    base = 9'd120;
				4'd5:    base = 9'd151;
				4'd6:    base = 9'd181;
				4'd7:    base = 9'd212;
				4'd8:    base = 9'd243;
				4'd9:    base = 9'd273;
				4'd10:   base = 9'd304;
				4'd11:   base = 9'd334;
				default: base = 9'd0;
			endcase
			efdc_month_start = base + ((leap && (mi >= 4'd2)) ? 9'd1 : 9'd0);
		end
	endfunction

	// Length of month 1..12; any other month number gives zero.
	function automatic dom_t efdc_month_len(input month_t month, input logic leap);
		dom_t len;
		begin
			case (month)
				4'd1:    len = 5'd31;
				MON_FEB: len = leap ? 5'd29 : 5'd28;
				MON_MAR: len = 5'd31;
				MON_APR: len = 5'd30;
				4'd5:    len = 5'd31;
				4'd6:    len = 5'd30;
				4'd7:    len = 5'd31;
				4'd8:    len = 5'd31;
				4'd9:    len = 5'd30;
				4'd10:   len = 5'd31;
				4'd11:   len = 5'd30;
				4'd12:   len = 5'd31;
				default: len = 5'd0;
			endcase
			efdc_month_len = len;
		end
	endfunction

endpackage

// ----- hw/rtl/efdc_split.sv -----
// ----------------------------------------------------------------------------
// efdc_split: day of year to month and day of month
// Compares the day against every month start after January in parallel and
// subtracts the start of the month that contains it.
// ----------------------------------------------------------------------------
module efdc_split (
	input  efdc_pkg::doy_t   doy,
	input  logic             leap,
	output efdc_pkg::month_t mon,
	output efdc_pkg::dom_t   dom
);
	import efdc_pkg::*;

	logic [3:0] mi;
	doy_t       ofs;

	always_comb begin
		mi = 4'd0;
		for (int t = 1; t < 12; t++) begin
			if (efdc_month_start(4'(t), leap) < doy) begin
				mi = 4'(t);
			end
		end
		ofs = doy - efdc_month_start(mi, leap);
		mon = mi + 4'd1;
		dom = ofs[DOM_W-1:0];
	end

endmodule

// ----- hw/rtl/easter_feast_date_calculator.sv -----
// ----------------------------------------------------------------------------
// easter_feast_date_calculator: Gregorian Easter and movable feast dates
// Computes Easter Sunday with the anonymous Gregorian computus and derives
// Good Friday, Ascension, Whitsunday and Carnival, plus leap and month length.
// ----------------------------------------------------------------------------
// Usage:
// A beat on the slave stream carries a year and a month number. Every accepted
// beat produces exactly one beat on the master stream with the leap flag, the
// length of the requested month (zero for a month outside 1 to 12) and the
// month and day of Easter Sunday and of the four feasts tied to it.
// The block is an eight-stage pipeline: the input register, six stages that
// break up the computus (divisions by 100 and 19, the century terms, the epact,
// the weekday correction, the Easter date, the day of year) and the result
// register. An accepted beat moves through the stage registers in order, waiting
// wherever the next stage is full, and leaves from the result register. One beat
// per cycle is sustained while the receiver takes beats; the logic between stage
// registers holds narrow constant multiplications, adds, subtracts and compares.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor moves, so a stalled receiver only blocks once every stage is full;
// bubbles are squeezed out and s_axis_tready stays high until then.
// Reset clears all valid bits; no result is pending afterwards.
// ----------------------------------------------------------------------------
module easter_feast_date_calculator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // year[13:0], month[17:14], zero pad [23:18]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// is_leap[0], month_days[5:1], easter_mon[8:6], easter_dom[13:9],
	// friday_mon[16:14], friday_dom[21:17], ascension_mon[24:22],
	// ascension_dom[29:25], whitsun_mon[32:30], whitsun_dom[37:33],
	// carnival_mon[39:38], carnival_dom[44:40], zero pad [47:45]
	output logic [47:0] m_axis_tdata
);
	import efdc_pkg::*;

	localparam int NSTG = 8;

	// Valid bit per stage and the load enables that ripple back from the output.
	logic [NSTG:1] stg_vld_q;
	logic [NSTG:1] stg_ld;

	always_comb begin
		stg_ld[NSTG] = !stg_vld_q[NSTG] || m_axis_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			stg_ld[k] = !stg_vld_q[k] || stg_ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			if (stg_ld[1]) begin
				stg_vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (stg_ld[k]) begin
					stg_vld_q[k] <= stg_vld_q[k-1];
				end
			end
		end
	end

	assign s_axis_tready = stg_ld[1];
	assign m_axis_tvalid = stg_vld_q[NSTG];

	// Stage 1: input register.
	year_t  year_s1;
	month_t month_s1;

	always_ff @(posedge clk) begin
		if (stg_ld[1]) begin
			year_s1  <= s_axis_tdata[13:0];
			month_s1 <= s_axis_tdata[17:14];
		end
	end

	// Stage 2: century b = year / 100 and year / 19 by reciprocal multiplication.
	logic [26:0] prod100;
	logic [29:0] prod19;
	year_t       year_s2;
	month_t      month_s2;
	logic [7:0]  b_s2;
	logic [9:0]  q19_s2;

	assign prod100 = 27'(year_s1) * 27'(DIV100_MUL);
	assign prod19  = 30'(year_s1) * 30'(DIV19_MUL);

	always_ff @(posedge clk) begin
		if (stg_ld[2]) begin
			year_s2  <= year_s1;
			month_s2 <= month_s1;
			b_s2     <= prod100[26:19];
			q19_s2   <= prod19[29:20];
		end
	end

	// Stage 3: golden number a, year in century c, the century corrections and the
	// leap flag. Divisibility by 4 of the year follows from c since 100 is a multiple of 4.
	year_t       rem19;
	year_t       rem100;
	logic [14:0] fprod;
	logic [8:0]  gx;
	logic [18:0] gprod;
	logic [2:0]  f_val;
	logic        leap_c;
	month_t      month_s3;
	logic [4:0]  a_s3;
	logic [7:0]  b_s3;
	logic [6:0]  c_s3;
	logic [5:0]  d_s3;
	logic [1:0]  e_s3;
	logic [5:0]  g_s3;
	logic        leap_s3;

	always_comb begin
		rem19  = year_s2 - 14'(14'(q19_s2) * 14'd19);
		rem100 = year_s2 - 14'(14'(b_s2) * 14'd100);
		fprod  = 15'(9'(b_s2) + 9'd8) * 15'(DIV25_MUL);
		f_val  = fprod[12:10];
		gx     = 9'(b_s2) - 9'(f_val) + 9'd1;
		gprod  = 19'(gx) * 19'(DIV3_MUL);
		leap_c = (rem100[1:0] == 2'd0) && ((rem100[6:0] != 7'd0) || (b_s2[1:0] == 2'd0));
	end

	always_ff @(posedge clk) begin
		if (stg_ld[3]) begin
			month_s3 <= month_s2;
			a_s3     <= rem19[4:0];
			b_s3     <= b_s2;
			c_s3     <= rem100[6:0];
			d_s3     <= b_s2[7:2];
			e_s3     <= b_s2[1:0];
			g_s3     <= gprod[16:11];
			leap_s3  <= leap_c;
		end
	end

	// Stage 4: epact h = (19a + b - d - g + 15) mod 30.
	logic [9:0]  hx;
	logic [20:0] hprod;
	logic [9:0]  hrem;
	month_t      month_s4;
	logic [4:0]  a_s4;
	logic [4:0]  h_s4;
	logic [1:0]  e_s4;
	logic [4:0]  i_s4;
	logic [1:0]  k_s4;
	logic        leap_s4;

	always_comb begin
		hx    = 10'(a_s3) * 10'd19 + 10'(b_s3) - 10'(d_s3) - 10'(g_s3) + 10'd15;
		hprod = 21'(hx) * 21'(DIV30_MUL);
		hrem  = hx - 10'(10'(hprod[19:15]) * 10'd30);
	end

	always_ff @(posedge clk) begin
		if (stg_ld[4]) begin
			month_s4 <= month_s3;
			a_s4     <= a_s3;
			h_s4     <= hrem[4:0];
			e_s4     <= e_s3;
			i_s4     <= c_s3[6:2];
			k_s4     <= c_s3[1:0];
			leap_s4  <= leap_s3;
		end
	end

	// Stage 5: weekday correction l = (32 + 2e + 2i - h - k) mod 7.
	logic [7:0]  lx;
	logic [15:0] lprod;
	logic [7:0]  lrem;
	month_t      month_s5;
	logic [4:0]  a_s5;
	logic [4:0]  h_s5;
	logic [2:0]  l_s5;
	logic        leap_s5;

	always_comb begin
		lx    = 8'd32 + 8'(e_s4) * 8'd2 + 8'(i_s4) * 8'd2 - 8'(h_s4) - 8'(k_s4);
		lprod = 16'(lx) * 16'(DIV7_MUL);
		lrem  = lx - 8'(8'(lprod[14:11]) * 8'd7);
	end

	always_ff @(posedge clk) begin
		if (stg_ld[5]) begin
			month_s5 <= month_s4;
			a_s5     <= a_s4;
			h_s5     <= h_s4;
			l_s5     <= lrem[2:0];
			leap_s5  <= leap_s4;
		end
	end

	// Stage 6: Easter date. The quotient (a + 11h + 22l) / 451 is only ever 0 or 1,
	// and h + l + 114 - 7m always falls in March or April.
	logic [8:0] mx;
	logic       m_bit;
	logic [7:0] base;
	logic       apr;
	logic [7:0] dom_x;
	month_t     month_s6;
	month_t     emon_s6;
	dom_t       edom_s6;
	logic       leap_s6;

	always_comb begin
		mx    = 9'(a_s5) + 9'(h_s5) * 9'd11 + 9'(l_s5) * 9'd22;
		m_bit = (mx >= 9'd451);
		base  = 8'(h_s5) + 8'(l_s5) + 8'd114 - (m_bit ? 8'd7 : 8'd0);
		apr   = (base >= 8'd124);
		dom_x = base - (apr ? 8'd124 : 8'd93) + 8'd1;
	end

	always_ff @(posedge clk) begin
		if (stg_ld[6]) begin
			month_s6 <= month_s5;
			emon_s6  <= apr ? MON_APR : MON_MAR;
			edom_s6  <= dom_x[4:0];
			leap_s6  <= leap_s5;
		end
	end

	// Stage 7: Easter as a day of the year, and the requested month length.
	doy_t   doy_s7;
	month_t emon_s7;
	dom_t   edom_s7;
	dom_t   mdays_s7;
	logic   leap_s7;

	always_ff @(posedge clk) begin
		if (stg_ld[7]) begin
			doy_s7   <= efdc_month_start(emon_s6 - 4'd1, leap_s6) + 9'(edom_s6);
			emon_s7  <= emon_s6;
			edom_s7  <= edom_s6;
			mdays_s7 <= efdc_month_len(month_s6, leap_s6);
			leap_s7  <= leap_s6;
		end
	end

	// Stage 8: the four feasts split back into month and day; result register.
	month_t fri_mon, asc_mon, whi_mon, car_mon;
	dom_t   fri_dom, asc_dom, whi_dom, car_dom;

	efdc_split u_split_fri (
		.doy  (doy_s7 - FRIDAY_OFS),
		.leap (leap_s7),
		.mon  (fri_mon),
		.dom  (fri_dom)
	);

	efdc_split u_split_asc (
		.doy  (doy_s7 + ASCENSION_OFS),
		.leap (leap_s7),
		.mon  (asc_mon),
		.dom  (asc_dom)
	);

	efdc_split u_split_whi (
		.doy  (doy_s7 + WHITSUN_OFS),
		.leap (leap_s7),
		.mon  (whi_mon),
		.dom  (whi_dom)
	);

	efdc_split u_split_car (
		.doy  (doy_s7 - CARNIVAL_OFS),
		.leap (leap_s7),
		.mon  (car_mon),
		.dom  (car_dom)
	);

	logic [44:0] res_s8;

	always_ff @(posedge clk) begin
		if (stg_ld[8]) begin
			res_s8 <= {car_dom, car_mon[1:0],
			           whi_dom, whi_mon[2:0],
			           asc_dom, asc_mon[2:0],
			           fri_dom, fri_mon[2:0],
			           edom_s7, emon_s7[2:0],
			           mdays_s7, leap_s7};
		end
	end

	assign m_axis_tdata = {3'b000, res_s8};

endmodule
